// ----- rtl/fid_pkg.sv -----
`timescale 1ns / 1ps

package fid_pkg;

  // Default number of slots in the set.
  localparam int SLOT_COUNT_DEF = 16;

  // Widths of the item fields.
  localparam int ACT_W = 2;
  localparam int ID_W  = 16;
  localparam int OCC_W = 5;

  // Largest count that the occupancy field can show.
  localparam logic [OCC_W-1:0] OCC_MAX = 5'd31;

  // Operation codes carried in the action field.
  typedef enum logic [ACT_W-1:0] {
    ACT_ADD   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NOP   = 2'd3
  } act_t;

  // Operation item as it travels from cell to cell.
  typedef struct packed {
    logic            valid;
    act_t            action;
    logic [ID_W-1:0] event_id;
    logic            found;    // some earlier cell held the id
    logic            claimed;  // some earlier cell took the id provisionally
  } pkt_t;

  // Broadcast from the end of the chain once an operation has finished.
  typedef struct packed {
    logic commit;  // operation complete: provisional marks are settled
    logic abort;   // the provisional add must be undone
  } ctl_t;

endpackage

// ----- rtl/fid_cell.sv -----
`timescale 1ns / 1ps

module fid_cell #(
  parameter int CNT_W = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fid_pkg::pkt_t        pkt_i,
  input  logic [CNT_W-1:0]     cnt_i,
  input  fid_pkg::ctl_t        ctl_i,
  output fid_pkg::pkt_t        pkt_o,
  output logic [CNT_W-1:0]     cnt_o
);
  import fid_pkg::*;

  logic [ID_W-1:0]  slot_r, slot_nxt;
  logic             tent_r, tent_nxt;
  pkt_t             pkt_r, pkt_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             match;

  assign match = (slot_r == pkt_i.event_id);

  // Apply the passing operation to this slot and update the item for the next cell.
  always_comb begin
    slot_nxt = slot_r;
    tent_nxt = tent_r;
    pkt_nxt  = pkt_i;
    cnt_nxt  = cnt_i;

    // Settle a provisional add once the whole chain has been seen.
    if (ctl_i.abort && tent_r) begin
      slot_nxt = '0;
    end
    if (ctl_i.commit) begin
      tent_nxt = 1'b0;
    end

    if (pkt_i.valid) begin
      case (pkt_i.action)
        ACT_ADD: begin
          if (pkt_i.event_id != '0) begin
            if (match) begin
              pkt_nxt.found = 1'b1;
            end else if (slot_r == '0 && !pkt_i.found && !pkt_i.claimed) begin
              // Lowest empty slot so far: take it, to be undone if a later cell matches.
              slot_nxt        = pkt_i.event_id;
              tent_nxt        = 1'b1;
              pkt_nxt.claimed = 1'b1;
            end
          end
        end
        ACT_CLEAR: begin
          if (match && !pkt_i.found) begin
            slot_nxt      = '0;
            pkt_nxt.found = 1'b1;
          end
        end
        ACT_QUERY: begin
          if (match) begin
            pkt_nxt.found = 1'b1;
          end
        end
        default: begin
        end
      endcase
      cnt_nxt = cnt_i + CNT_W'(slot_nxt != '0);
    end
  end

  // Slot state and the item handed on; only the valid flag of the item is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      tent_r      <= 1'b0;
      pkt_r.valid <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
      tent_r <= tent_nxt;
      pkt_r  <= pkt_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign pkt_o = pkt_r;
  assign cnt_o = cnt_r;

endmodule

// ----- rtl/fault_id_record_set_top.sv -----
`timescale 1ns / 1ps

// Set of fault-event ids held in a row of SLOT_COUNT slot cells.
// Input channel in_*: one item per operation, tdata carries action (add,
// clear, query, no-op) and a 16-bit event id. Result channel out_*: exactly one
// item per operation with found, dropped and the occupied-slot count.
// An operation enters the first cell and moves one cell per cycle; each
// cell compares, claims or clears its own slot as the item passes. An add
// takes the lowest empty slot provisionally and the claim is withdrawn when
// the item leaves the last cell having met the id further along.
// The item passes through the cell registers, then the result stage and the
// output register. One operation is in flight at a time, so the block takes
// no new item until the previous one has walked the cell row and its result
// has moved on from the result stage. in_tready is high whenever no operation is
// in flight. Reset empties every slot and discards anything in flight. If
// the receiver stalls, the finished result waits in the output register and
// one more result waits behind it; the next operation is then held off
// until the output side drains.
module fault_id_record_set_top #(
  parameter int SLOT_COUNT = fid_pkg::SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [1:0] action, [17:2] event_id, [23:18] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [0] found, [1] dropped, [6:2] occupied, [7] zero
);
  import fid_pkg::*;

  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int EXT_W = (CNT_W > OCC_W) ? CNT_W : OCC_W;

  pkt_t             pkt_w [0:SLOT_COUNT];
  logic [CNT_W-1:0] cnt_w [0:SLOT_COUNT];
  ctl_t             ctl;

  logic             busy_r;
  logic             accept;
  pkt_t             end_pkt;
  logic [CNT_W-1:0] cnt_adj;
  logic [EXT_W-1:0] cnt_ext;
  logic [OCC_W-1:0] occ;
  logic             drop;

  logic             res_valid_r;
  logic             res_found_r;
  logic             res_dropped_r;
  logic [OCC_W-1:0] res_occ_r;
  logic             res_move;

  logic             out_valid_r;
  logic [7:0]       out_data_r;

  assign in_tready = !busy_r;
  assign accept    = in_tvalid && in_tready;

  // Inject the accepted operation into the first cell.
  assign pkt_w[0] = {accept, act_t'(in_tdata[ACT_W-1:0]),
                     in_tdata[ACT_W+ID_W-1:ACT_W], 1'b0, 1'b0};
  assign cnt_w[0] = '0;

  // Row of slot cells.
  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    fid_cell #(
      .CNT_W (CNT_W)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .pkt_i (pkt_w[i]),
      .cnt_i (cnt_w[i]),
      .ctl_i (ctl),
      .pkt_o (pkt_w[i+1]),
      .cnt_o (cnt_w[i+1])
    );
  end

  // Finish the operation as it leaves the last cell.
  always_comb begin
    end_pkt    = pkt_w[SLOT_COUNT];
    ctl.commit = end_pkt.valid;
    ctl.abort  = end_pkt.valid && end_pkt.action == ACT_ADD &&
                 end_pkt.found && end_pkt.claimed;
    drop       = end_pkt.action == ACT_ADD && end_pkt.event_id != '0 &&
                 !end_pkt.found && !end_pkt.claimed;
    cnt_adj    = cnt_w[SLOT_COUNT] - CNT_W'(ctl.abort);
    cnt_ext    = EXT_W'(cnt_adj);
    occ        = (cnt_ext > EXT_W'(OCC_MAX)) ? OCC_MAX : cnt_ext[OCC_W-1:0];
  end

  assign res_move = res_valid_r && (!out_valid_r || out_tready);

  // Control: busy flag, result stage and output register occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
      end else if (res_move) begin
        busy_r <= 1'b0;
      end
      if (end_pkt.valid) begin
        res_valid_r <= 1'b1;
      end else if (res_move) begin
        res_valid_r <= 1'b0;
      end
      if (res_move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (end_pkt.valid) begin
      res_found_r   <= end_pkt.found;
      res_dropped_r <= drop;
      res_occ_r     <= occ;
    end
    if (res_move) begin
      out_data_r <= {1'b0, res_occ_r, res_dropped_r, res_found_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import fid_pkg::*;

  localparam int SLOTS      = SLOT_COUNT_DEF;
  localparam int DRAIN_WAIT = SLOTS + 6;
  localparam int STALL_MAX  = 2000;

  // Outcome of one operation as the result channel reports it.
  typedef struct packed {
    logic             found;
    logic             dropped;
    logic [OCC_W-1:0] occupied;
  } op_outcome_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [1:0] action, [17:2] event_id, [23:18] zero
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [0] found, [1] dropped, [6:2] occupied, [7] zero

  // Shadow copy of the slot store and the outcomes still owed by the block.
  logic [ID_W-1:0] shadow_slots [SLOTS];
  op_outcome_t     outcomes_due [$];

  int  fail_count = 0;
  int  quiet_cycles = 0;
  bit  send_idles;
  bit  recv_stalls;

  fault_id_record_set_top #(.SLOT_COUNT(SLOTS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Apply one operation to the shadow store and return what the block must report.
  function automatic op_outcome_t apply_op(act_t op, logic [ID_W-1:0] id);
    op_outcome_t res;
    int          hit;
    int          free_slot;
    int          n;
    res       = '0;
    hit       = -1;
    free_slot = -1;
    n         = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0 && shadow_slots[i] == id) hit = i;
      if (free_slot < 0 && shadow_slots[i] == '0) free_slot = i;
    end
    case (op)
      ACT_ADD: begin
        // An id of zero is the empty marker and is never stored.
        if (id != '0) begin
          if (hit >= 0) begin
            res.found = 1'b1;
          end else if (free_slot >= 0) begin
            shadow_slots[free_slot] = id;
          end else begin
            res.dropped = 1'b1;
          end
        end
      end
      ACT_CLEAR: begin
        if (hit >= 0) begin
          res.found         = 1'b1;
          shadow_slots[hit] = '0;
        end
      end
      ACT_QUERY: begin
        res.found = (hit >= 0);
      end
      default: begin
      end
    endcase
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_slots[i] != '0) n++;
    end
    res.occupied = (n > int'(OCC_MAX)) ? OCC_MAX : OCC_W'(n);
    return res;
  endfunction

  // Offer one item, wait for it to be taken, then record the expected outcome.
  task automatic send_op(act_t op, logic [ID_W-1:0] id);
    int gap;
    gap = send_idles ? $urandom_range(0, 5) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, id, op};
    do @(posedge clk); while (!in_tready);
    outcomes_due.push_back(apply_op(op, id));
  endtask

  // Hold the input side off until every outstanding outcome has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
  endtask

  // Extremes of the id field, every action and the zero-id cases on an empty set.
  task automatic test_edge_ids();
    send_idles  = 1'b0;
    recv_stalls = 1'b0;
    send_op(ACT_QUERY, 16'h0000);
    send_op(ACT_ADD,   16'h0000);
    send_op(ACT_CLEAR, 16'h0000);
    send_op(ACT_NOP,   16'h0000);
    send_op(ACT_ADD,   16'h0001);
    send_op(ACT_ADD,   16'hFFFF);
    send_op(ACT_ADD,   16'hFFFF);
    send_op(ACT_QUERY, 16'hFFFF);
    send_op(ACT_QUERY, 16'h1234);
    send_op(ACT_NOP,   16'hFFFF);
    send_op(ACT_CLEAR, 16'h0001);
    send_op(ACT_CLEAR, 16'h0001);
    send_op(ACT_QUERY, 16'h0001);
    send_op(ACT_ADD,   16'h8000);
    send_op(ACT_ADD,   16'h5555);
    send_op(ACT_ADD,   16'hAAAA);
    send_op(ACT_QUERY, 16'h0000);
    send_op(ACT_CLEAR, 16'hFFFF);
    send_op(ACT_CLEAR, 16'h8000);
    send_op(ACT_CLEAR, 16'h5555);
    send_op(ACT_CLEAR, 16'hAAAA);
    send_op(ACT_QUERY, 16'hAAAA);
  endtask

  // Fill every slot, overflow the set, then reuse a freed slot and empty it again.
  task automatic test_full_set();
    logic [ID_W-1:0] ids [SLOTS];
    logic [ID_W-1:0] extra;
    int              pick;
    send_idles  = 1'b1;
    recv_stalls = 1'b1;
    // Low five bits make the ids distinct and nonzero; the rest is random.
    for (int i = 0; i < SLOTS; i++) begin
      ids[i] = ID_W'(($urandom & 32'hFFE0) | 32'h10 | i);
      send_op(ACT_ADD, ids[i]);
    end
    extra = ID_W'(($urandom & 32'hFFE0) | 32'h1);
    send_op(ACT_ADD,   extra);
    send_op(ACT_ADD,   ids[SLOTS-1]);
    send_op(ACT_QUERY, 16'h0000);
    send_op(ACT_CLEAR, 16'h0000);
    send_op(ACT_ADD,   16'h0000);
    send_op(ACT_NOP,   extra);
    wait_drained();
    // A freed middle slot is the only gap, so the next add must land there.
    pick = $urandom_range(1, SLOTS - 2);
    send_op(ACT_CLEAR, ids[pick]);
    send_op(ACT_ADD,   extra);
    ids[pick] = extra;
    send_op(ACT_ADD,   ID_W'(extra ^ 16'h0002));
    send_op(ACT_QUERY, extra);
    wait_drained();
    for (int i = SLOTS - 1; i >= 0; i--) begin
      send_op(ACT_CLEAR, ids[i]);
    end
    send_op(ACT_QUERY, ids[0]);
  endtask

  // Rounds of traffic over a small pool of ids so that hits, fills and drops recur.
  task automatic test_random_traffic();
    logic [ID_W-1:0] pool [24];
    int              add_pct;
    int              clear_pct;
    int              roll;
    logic [ID_W-1:0] id;
    act_t            op;
    for (int round = 0; round < 12; round++) begin
      for (int i = 0; i < 24; i++) begin
        pool[i] = ID_W'($urandom);
      end
      if ($urandom_range(0, 1) == 0) pool[0] = '0;
      case ($urandom_range(0, 2))
        0:       add_pct = 30;
        1:       add_pct = 50;
        default: add_pct = 70;
      endcase
      clear_pct   = (100 - add_pct) / 2;
      send_idles  = ($urandom_range(0, 3) != 0);
      recv_stalls = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < 100; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < add_pct) begin
          op = ACT_ADD;
        end else if (roll < add_pct + clear_pct) begin
          op = ACT_CLEAR;
        end else if (roll < 96) begin
          op = ACT_QUERY;
        end else begin
          op = ACT_NOP;
        end
        if ($urandom_range(0, 9) == 0) begin
          id = ID_W'($urandom);
        end else begin
          id = pool[$urandom_range(0, 23)];
        end
        send_op(op, id);
      end
      if ($urandom_range(0, 1) == 0) wait_drained();
    end
  endtask

  // Receiver: a random stall before each result, except in stall-free stretches.
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = recv_stalls ? $urandom_range(0, 5) : 0;
      repeat (stall) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Result checker: each accepted item against the oldest expected outcome.
  always @(posedge clk) begin
    op_outcome_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (outcomes_due.size() == 0) begin
        $error("unexpected result item: tdata %02h", out_tdata);
        fail_count++;
      end else begin
        want = outcomes_due.pop_front();
        if (out_tdata[0] !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_tdata[0]);
          fail_count++;
        end
        if (out_tdata[1] !== want.dropped) begin
          $error("dropped: expected %0d, got %0d", want.dropped, out_tdata[1]);
          fail_count++;
        end
        if (out_tdata[6:2] !== want.occupied) begin
          $error("occupied: expected %0d, got %0d", want.occupied, out_tdata[6:2]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long without any item moving on either side ends the run.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    send_idles   = 1'b0;
    recv_stalls  = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    rst_n        = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_slots[i] = '0;
    end
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_edge_ids();
    test_full_set();
    test_random_traffic();

    // Let the last results arrive, then watch for stray ones.
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (outcomes_due.size() == 0 && fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/fid_pkg.sv
rtl/fid_cell.sv
rtl/fault_id_record_set_top.sv
tb/sv/tb.sv
